### rtl/cbst_pkg.sv
// Shared types, codes and lookup functions for the context bank shadow tracker.
// Depends on nothing; every other file of the block imports it.
package cbst_pkg;

  // Queue between the decode front and the execute back.
  localparam int unsigned QueueDepth = 2;

  // Context word: low page bits, bit 0 forces a load.
  localparam logic [31:0] PageMask      = 32'h0000_1FFF;
  // Descriptor bits allowed on the first range and on the later ones.
  localparam logic [31:0] FirstDescMask = 32'h0107_FFFF;
  localparam logic [31:0] LaterDescMask = 32'h0007_FFFF;
  localparam int unsigned DescEnableBit = 24;

  // Register windows of the three banks.
  localparam logic [31:0] Win0Base = 32'h0000_4000;
  localparam logic [31:0] Win0End  = 32'h0000_4800;
  localparam logic [31:0] Win1Base = 32'h0000_4800;
  localparam logic [31:0] Win1End  = 32'h0000_48C0;
  localparam logic [31:0] Win2Base = 32'h0000_2000;
  localparam logic [31:0] Win2End  = 32'h0000_2400;

  // Bank types carried in the descriptor.
  localparam logic [2:0] TypeBank0 = 3'd0;
  localparam logic [2:0] TypeBank1 = 3'd1;
  localparam logic [2:0] TypeBank2 = 3'd4;

  // Item modes.
  localparam logic [1:0] ModeHeader = 2'd0;
  localparam logic [1:0] ModeRange  = 2'd1;
  localparam logic [1:0] ModeShadow = 2'd2;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_COPY   = 2'd1,
    ACT_SHADOW = 2'd2,
    ACT_ERROR  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_LENGTH  = 2'd1,
    ERR_ADDRESS = 2'd2,
    ERR_RANGE   = 2'd3
  } error_e;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_RANGE  = 2'd2,
    KIND_SHADOW = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] payload_words;
    logic [31:0] context_word;
    logic [31:0] descriptor;
    logic [31:0] range_count;
    logic [31:0] shadow_index;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    action_e     action;
    logic [15:0] register_index;
    logic [31:0] memory_address;
    logic [11:0] word_count;
    logic [31:0] memory_data;
    error_e      error_code;
    logic        packet_done;
  } out_item_t;

  // Decoded item handed from front to back.
  typedef struct packed {
    kind_e       kind;
    // header
    logic        len_ok;
    logic [14:0] ranges;
    logic [31:0] ctx;
    // range
    logic [2:0]  rtype;
    logic        type_ok;
    logic        enable;
    logic        bad_first;
    logic        bad_later;
    logic        range_ok;
    logic        nonzero;
    logic [15:0] reg_index;
    logic [17:0] off_x4;
    logic [11:0] count;
    // shadow write
    logic        sh_hit;
    logic [1:0]  sh_slot;
    logic [12:0] sh_off_x4;
    logic [31:0] data;
  } op_t;

  function automatic logic [1:0] slot_of(input logic [2:0] t);
    logic [1:0] s;
    s = (t == TypeBank2) ? 2'd2 : ((t == TypeBank1) ? 2'd1 : 2'd0);
    return s;
  endfunction

  function automatic logic [15:0] window_of(input logic [2:0] t);
    logic [15:0] w;
    w = (t == TypeBank2) ? Win2Base[15:0] : ((t == TypeBank1) ? Win1Base[15:0] : Win0Base[15:0]);
    return w;
  endfunction

  function automatic logic [11:0] limit_of(input logic [2:0] t);
    logic [11:0] l;
    l = (t == TypeBank2) ? 12'd1024 : ((t == TypeBank1) ? 12'd192 : 12'd2048);
    return l;
  endfunction

endpackage

### rtl/gpu_context_bank_shadow_tracker.sv
// Top level of the context bank shadow tracker: decode front, queue, execute back.
// Depends on cbst_pkg, cbst_front, cbst_queue and cbst_back.
//
//   Channel | Direction | Handshake                    | Beat
//   in      | input     | in_valid_i / in_stall_o      | cbst_pkg::in_item_t
//   out     | output    | out_valid_o / out_stall_i    | cbst_pkg::out_item_t
//
// One item per cycle sustained while out_stall_i stays low; each item gives exactly one result beat.
// After its item is accepted, a result passes the queue and then the output register.
// The queue holds QueueDepth decoded items, so input keeps flowing while a
// result waits; in_stall_o rises only when the queue is full.
// Reset clears all bank and packet state at once; no clearing pass.
module gpu_context_bank_shadow_tracker #(
  parameter int unsigned QueueDepth = cbst_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cbst_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cbst_pkg::out_item_t out_item_o
);
  import cbst_pkg::*;

  op_t  dec_op;
  op_t  head_op;
  logic q_full;
  logic q_valid;
  logic q_pop;

  assign in_stall_o = q_full;

  cbst_front u_front (
    .item_i (in_item_i),
    .op_o   (dec_op)
  );

  cbst_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (in_valid_i),
    .push_op_i (dec_op),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .head_o    (head_op)
  );

  cbst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_i        (head_op),
    .op_pop_o    (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

### rtl/cbst_front.sv
// Decode front: classifies one input beat and precomputes its checks and offsets.
// Depends on cbst_pkg.
module cbst_front (
  input  cbst_pkg::in_item_t item_i,
  output cbst_pkg::op_t      op_o
);
  import cbst_pkg::*;

  logic [2:0]  t;
  logic [15:0] offset;
  logic [15:0] limit16;
  logic [31:0] sidx;
  logic [10:0] sh_off;

  always_comb begin
    t       = item_i.descriptor[18:16];
    offset  = item_i.descriptor[15:0];
    limit16 = {4'b0, limit_of(t)};
    sidx    = item_i.shadow_index;
    op_o    = '0;

    // Classify by mode
    case (item_i.mode)
      ModeHeader: op_o.kind = KIND_HEADER;
      ModeRange:  op_o.kind = KIND_RANGE;
      ModeShadow: op_o.kind = KIND_SHADOW;
      default:    op_o.kind = KIND_NONE;
    endcase

    // Header: odd length of at least three words
    op_o.len_ok = (item_i.payload_words >= 16'd3) && item_i.payload_words[0];
    op_o.ranges = item_i.payload_words[15:1];
    op_o.ctx    = item_i.context_word;

    // Range: checks that need only the descriptor and count
    op_o.rtype     = t;
    op_o.type_ok   = (t == TypeBank0) || (t == TypeBank1) || (t == TypeBank2);
    op_o.enable    = item_i.descriptor[DescEnableBit];
    op_o.bad_first = (item_i.descriptor & ~FirstDescMask) != '0;
    op_o.bad_later = (item_i.descriptor & ~LaterDescMask) != '0;
    op_o.range_ok  = (offset <= limit16) &&
                     (item_i.range_count <= {16'b0, limit16 - offset});
    op_o.nonzero   = item_i.range_count != '0;
    op_o.reg_index = window_of(t) + offset;
    op_o.off_x4    = {offset, 2'b00};
    op_o.count     = item_i.range_count[11:0];

    // Shadow write: find the window and the word offset in it
    sh_off = '0;
    if (sidx >= Win0Base && sidx < Win0End) begin
      op_o.sh_hit  = 1'b1;
      op_o.sh_slot = 2'd0;
      sh_off       = sidx[10:0] - Win0Base[10:0];
    end else if (sidx >= Win1Base && sidx < Win1End) begin
      op_o.sh_hit  = 1'b1;
      op_o.sh_slot = 2'd1;
      sh_off       = sidx[10:0] - Win1Base[10:0];
    end else if (sidx >= Win2Base && sidx < Win2End) begin
      op_o.sh_hit  = 1'b1;
      op_o.sh_slot = 2'd2;
      sh_off       = sidx[10:0] - Win2Base[10:0];
    end
    op_o.sh_off_x4 = {sh_off, 2'b00};
    op_o.data      = item_i.write_data;
  end

endmodule

### rtl/cbst_queue.sv
// Short FIFO of decoded items between the front and the back.
// Depends on cbst_pkg for the item type.
module cbst_queue #(
  parameter int unsigned Depth = cbst_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cbst_pkg::op_t push_op_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output cbst_pkg::op_t head_o
);
  import cbst_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  op_t             store_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign head_o  = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

### rtl/cbst_back.sv
// Execute back: keeps bank and packet state, builds one result per item
// and holds it in the output register. Depends on cbst_pkg.
module cbst_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                op_valid_i,
  input  cbst_pkg::op_t       op_i,
  output logic                op_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cbst_pkg::out_item_t out_item_o
);
  import cbst_pkg::*;

  logic [18:0] bank_base_q [3];
  logic [2:0]  bank_en_q;
  logic [31:0] held_ctx_q, held_ctx_d;
  logic [14:0] left_q, left_d;
  logic [2:0]  ptype_q, ptype_d;
  logic        penable_q, penable_d;
  logic        pload_q, pload_d;
  logic        failed_q, failed_d;
  logic        first_q, first_d;
  logic        upd;
  logic [1:0]  upd_slot;

  logic        out_valid_q;
  out_item_t   out_q;
  out_item_t   res;

  logic        pop;
  logic [1:0]  sel;
  logic [18:0] sel_base;
  logic        sel_en;
  logic [31:0] physical;
  logic [2:0]  ptype_eff;
  logic        load_eff;
  logic        enable_eff;

  assign pop         = op_valid_i && (!out_valid_q || !out_stall_i);
  assign op_pop_o    = pop;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign physical    = {held_ctx_q[31:13], 13'b0};

  // Execute one decoded item against the state
  always_comb begin
    res        = '0;
    held_ctx_d = held_ctx_q;
    left_d     = left_q;
    ptype_d    = ptype_q;
    penable_d  = penable_q;
    pload_d    = pload_q;
    failed_d   = failed_q;
    first_d    = first_q;
    upd        = 1'b0;
    upd_slot   = slot_of(ptype_q);
    sel        = (op_i.kind == KIND_RANGE) ? slot_of(op_i.rtype) : op_i.sh_slot;
    sel_base   = bank_base_q[sel];
    sel_en     = bank_en_q[sel];
    ptype_eff  = first_q ? op_i.rtype : ptype_q;
    enable_eff = first_q ? op_i.enable : penable_q;
    load_eff   = first_q ? (held_ctx_q[0] || !sel_en || sel_base != held_ctx_q[31:13])
                         : pload_q;

    if (pop) begin
      case (op_i.kind)
        KIND_HEADER: begin
          if (!op_i.len_ok) begin
            res.action     = ACT_ERROR;
            res.error_code = ERR_LENGTH;
            failed_d       = 1'b1;
            left_d         = '0;
            first_d        = 1'b0;
          end else begin
            held_ctx_d = op_i.ctx;
            left_d     = op_i.ranges;
            first_d    = 1'b1;
            failed_d   = 1'b0;
          end
        end
        KIND_RANGE: begin
          if (left_q == '0) begin
            // Stray range: drop silently after a failed packet
            if (!failed_q) begin
              res.action     = ACT_ERROR;
              res.error_code = ERR_RANGE;
              failed_d       = 1'b1;
            end
          end else if (first_q && (held_ctx_q[12:1] != '0 || op_i.bad_first ||
                                   !op_i.type_ok)) begin
            res.action     = ACT_ERROR;
            res.error_code = ERR_ADDRESS;
            failed_d       = 1'b1;
            left_d         = '0;
            first_d        = 1'b0;
          end else begin
            if (first_q) begin
              ptype_d   = op_i.rtype;
              penable_d = op_i.enable;
              pload_d   = load_eff;
              first_d   = 1'b0;
            end
            if ((!first_q && op_i.bad_later) || op_i.rtype != ptype_eff ||
                !op_i.range_ok) begin
              res.action     = ACT_ERROR;
              res.error_code = ERR_RANGE;
              failed_d       = 1'b1;
              left_d         = '0;
              first_d        = 1'b0;
            end else begin
              if (op_i.nonzero && load_eff) begin
                res.action         = ACT_COPY;
                res.register_index = op_i.reg_index;
                res.memory_address = physical + {14'b0, op_i.off_x4};
                res.word_count     = op_i.count;
              end
              left_d = left_q - 1'b1;
              // Last range: commit the bank
              if (left_q == 15'd1) begin
                upd             = 1'b1;
                upd_slot        = slot_of(ptype_eff);
                res.packet_done = 1'b1;
              end
            end
          end
        end
        KIND_SHADOW: begin
          if (op_i.sh_hit && sel_en) begin
            res.action         = ACT_SHADOW;
            res.memory_address = {sel_base, 13'b0} + {19'b0, op_i.sh_off_x4};
            res.memory_data    = op_i.data;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Packet and bank state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_ctx_q <= '0;
      left_q     <= '0;
      ptype_q    <= '0;
      penable_q  <= 1'b0;
      pload_q    <= 1'b0;
      failed_q   <= 1'b0;
      first_q    <= 1'b0;
      bank_en_q  <= '0;
      for (int i = 0; i < 3; i++) begin
        bank_base_q[i] <= '0;
      end
    end else begin
      held_ctx_q <= held_ctx_d;
      left_q     <= left_d;
      ptype_q    <= ptype_d;
      penable_q  <= penable_d;
      pload_q    <= pload_d;
      failed_q   <= failed_d;
      first_q    <= first_d;
      if (upd) begin
        bank_base_q[upd_slot] <= held_ctx_q[31:13];
        bank_en_q[upd_slot]   <= enable_eff;
      end
    end
  end

  // Output register: load on pop, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= res;
    end
  end

endmodule

### rtl/cbst_checker.sv
// Port-level checks for the context bank shadow tracker, bound to the top level.
// Depends on cbst_pkg and gpu_context_bank_shadow_tracker.
module cbst_port_checks (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_stall_i,
  input cbst_pkg::out_item_t out_item_i
);
  import cbst_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_item_i))
    else $error("stalled result beat changed");

  // Error code present exactly on error results
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((out_item_i.action == ACT_ERROR) == (out_item_i.error_code != ERR_NONE)))
    else $error("error code does not match action");

  // Copy fields only on copy results
  a_copy_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.action != ACT_COPY |->
      out_item_i.register_index == '0 && out_item_i.word_count == '0)
    else $error("copy fields set on a non-copy result");

  // Packet completion never rides on an error or a shadow write
  a_done_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.packet_done |->
      out_item_i.action == ACT_NONE || out_item_i.action == ACT_COPY)
    else $error("packet done on an error or shadow write");

endmodule

bind gpu_context_bank_shadow_tracker cbst_port_checks u_cbst_port_checks (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_i  (out_item_o)
);
